FILE: sv/vwwt_pkg.sv
// Shared types and codes for the value window watch table.
package vwwt_pkg;

    localparam int DefDepth = 16;
    localparam int IdxW     = 8;

    localparam logic [1:0] OpReq   = 2'd0;
    localparam logic [1:0] OpCan   = 2'd1;
    localparam logic [1:0] OpPur   = 2'd2;
    localparam logic [1:0] OpSet   = 2'd3;

    localparam logic [2:0] StOk       = 3'd0;
    localparam logic [2:0] StRepl     = 3'd1;
    localparam logic [2:0] StOutWin   = 3'd2;
    localparam logic [2:0] StNotFound = 3'd4;
    localparam logic [2:0] StFull     = 3'd5;

    typedef struct packed {
        logic               vld;
        logic [1:0]         op;
        logic [14:0]        pid;
        logic [31:0]        rid;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] nv;
        logic               rising;
        logic               ins;
        logic               inserted;
        logic [31:0]        newid;
        logic               found;
        logic [31:0]        f_id;
        logic [14:0]        f_pid;
        logic signed [31:0] f_lo;
        logic signed [31:0] f_hi;
        logic               best_vld;
        logic [IdxW-1:0]    best_idx;
        logic [31:0]        best_id;
        logic [14:0]        best_pid;
        logic signed [31:0] best_lo;
        logic signed [31:0] best_hi;
        logic               rm_vld;
        logic [IdxW-1:0]    rm_idx;
    } t_tok;

endpackage

FILE: sv/value_window_watch_table.sv
// Top level: control, level and id registers, and the chain of table cells.
//
//  channel | handshake          | payload
//  input   | i_valid / o_ready  | i_op i_pid i_req_id i_low_bound i_high_bound i_new_value
//  output  | o_valid / i_ready  | o_kind o_status o_out_req_id o_out_pid o_out_low
//          |                    | o_out_high o_current_value o_old_req_id o_last
//
// A scan token walks the cell chain, one cell per cycle; after each pass the result
// is held in the output registers until it is accepted.
// Request, cancel and purge take one pass; set level takes one pass per removed
// entry plus one, each result waiting for acceptance before the next pass.
// One request in flight at a time; o_ready is high only while idle.
// Synchronous active-low reset empties the table, zeroes level and id counter.
module value_window_watch_table #(
    parameter int DEPTH = vwwt_pkg::DefDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [14:0] i_pid,
    input  logic [31:0] i_req_id,
    input  logic signed [31:0] i_low_bound,
    input  logic signed [31:0] i_high_bound,
    input  logic signed [31:0] i_new_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [2:0]  o_status,
    output logic [31:0] o_out_req_id,
    output logic [14:0] o_out_pid,
    output logic signed [31:0] o_out_low,
    output logic signed [31:0] o_out_high,
    output logic signed [31:0] o_current_value,
    output logic [31:0] o_old_req_id,
    output logic        o_last
);

    localparam logic [1:0] SIdle = 2'd0;
    localparam logic [1:0] SRun  = 2'd1;
    localparam logic [1:0] SOut  = 2'd2;

    logic [1:0]         r_state;
    logic signed [31:0] r_level;
    logic [31:0]        r_cnt;
    vwwt_pkg::t_tok     r_tok;
    vwwt_pkg::t_tok     r_next;
    logic               r_kind;
    logic [2:0]         r_status;
    logic [31:0]        r_rid;
    logic [14:0]        r_pid;
    logic signed [31:0] r_lo;
    logic signed [31:0] r_hi;
    logic signed [31:0] r_cur;
    logic [31:0]        r_old;
    logic               r_last;

    vwwt_pkg::t_tok     w_tok [0:DEPTH];
    vwwt_pkg::t_tok     ret;
    vwwt_pkg::t_tok     start;
    vwwt_pkg::t_tok     again;
    logic               outwin;

    assign w_tok[0] = r_tok;
    assign ret      = w_tok[DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            vwwt_cell #(.CELL_IDX(g)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_tok  (w_tok[g]),
                .o_tok  (w_tok[g+1])
            );
        end
    endgenerate

    always_comb begin
        outwin         = (i_low_bound > r_level) || (i_high_bound < r_level);
        start          = '0;
        start.vld      = 1'b1;
        start.op       = i_op;
        start.pid      = i_pid;
        start.rid      = i_req_id;
        start.lo       = i_low_bound;
        start.hi       = i_high_bound;
        start.nv       = i_new_value;
        start.rising   = i_new_value > r_level;
        start.ins      = !outwin;
        start.newid    = r_cnt + 32'd1;
    end

    // next set-level pass: drop the entry just reported, restart the search
    always_comb begin
        again          = r_next;
        again.vld      = 1'b1;
        again.rm_vld   = 1'b1;
        again.rm_idx   = r_next.best_idx;
        again.best_vld = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SIdle;
            r_level   <= '0;
            r_cnt     <= '0;
            r_tok.vld <= 1'b0;
        end else begin
            unique case (r_state)
                SIdle: begin
                    if (i_valid) begin
                        r_tok   <= start;
                        r_state <= SRun;
                    end
                end
                SRun: begin
                    r_tok.vld <= 1'b0;
                    if (ret.vld) begin
                        r_state  <= SOut;
                        r_next   <= ret;
                        r_kind   <= 1'b0;
                        r_status <= vwwt_pkg::StOk;
                        r_rid    <= '0;
                        r_pid    <= '0;
                        r_lo     <= '0;
                        r_hi     <= '0;
                        r_cur    <= '0;
                        r_old    <= '0;
                        r_last   <= 1'b1;
                        unique case (ret.op)
                            vwwt_pkg::OpReq: begin
                                r_pid <= ret.f_pid;
                                r_lo  <= ret.f_lo;
                                r_hi  <= ret.f_hi;
                                r_old <= ret.f_id;
                                if (!ret.ins) begin
                                    r_status <= (ret.found ? vwwt_pkg::StRepl : vwwt_pkg::StOk)
                                                | vwwt_pkg::StOutWin;
                                    r_cur    <= r_level;
                                end else if (ret.inserted) begin
                                    r_status <= ret.found ? vwwt_pkg::StRepl : vwwt_pkg::StOk;
                                    r_rid    <= ret.newid;
                                    r_cnt    <= ret.newid;
                                end else begin
                                    r_status <= vwwt_pkg::StFull;
                                end
                            end
                            vwwt_pkg::OpCan, vwwt_pkg::OpPur: begin
                                r_status <= ret.found ? vwwt_pkg::StOk : vwwt_pkg::StNotFound;
                                r_rid    <= ret.f_id;
                                r_pid    <= ret.f_pid;
                                r_lo     <= ret.f_lo;
                                r_hi     <= ret.f_hi;
                            end
                            default: begin
                                r_cur <= ret.nv;
                                if (ret.best_vld) begin
                                    r_kind <= 1'b1;
                                    r_rid  <= ret.best_id;
                                    r_pid  <= ret.best_pid;
                                    r_lo   <= ret.best_lo;
                                    r_hi   <= ret.best_hi;
                                    r_last <= 1'b0;
                                end else begin
                                    r_level <= ret.nv;
                                end
                            end
                        endcase
                    end
                end
                SOut: begin
                    if (i_ready) begin
                        if (r_last) begin
                            r_state <= SIdle;
                        end else begin
                            r_tok   <= again;
                            r_state <= SRun;
                        end
                    end
                end
                default: r_state <= SIdle;
            endcase
        end
    end

    assign o_ready         = (r_state == SIdle);
    assign o_valid         = (r_state == SOut);
    assign o_kind          = r_kind;
    assign o_status        = r_status;
    assign o_out_req_id    = r_rid;
    assign o_out_pid       = r_pid;
    assign o_out_low       = r_lo;
    assign o_out_high      = r_hi;
    assign o_current_value = r_cur;
    assign o_old_req_id    = r_old;
    assign o_last          = r_last;

endmodule

FILE: sv/vwwt_cell.sv
// One table cell: holds an entry and updates the passing scan token.
module vwwt_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  vwwt_pkg::t_tok  i_tok,
    output vwwt_pkg::t_tok  o_tok
);

    logic               r_valid;
    logic [14:0]        r_pid;
    logic [31:0]        r_id;
    logic signed [31:0] r_lo;
    logic signed [31:0] r_hi;
    vwwt_pkg::t_tok     r_tok;

    logic               n_valid;
    logic [14:0]        n_pid;
    logic [31:0]        n_id;
    logic signed [31:0] n_lo;
    logic signed [31:0] n_hi;
    vwwt_pkg::t_tok     n_tok;

    logic               hit;
    logic               rmv;
    logic               cand;
    logic               better;
    logic signed [31:0] key;
    logic signed [31:0] bkey;

    always_comb begin
        n_valid = r_valid;
        n_pid   = r_pid;
        n_id    = r_id;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_tok   = i_tok;
        hit     = 1'b0;
        rmv     = 1'b0;
        cand    = 1'b0;
        better  = 1'b0;
        key     = i_tok.rising ? r_hi : r_lo;
        bkey    = i_tok.rising ? i_tok.best_hi : i_tok.best_lo;
        if (i_tok.vld) begin
            unique case (i_tok.op)
                vwwt_pkg::OpReq: begin
                    hit = r_valid && (r_pid == i_tok.pid) && !i_tok.found;
                    if (hit) begin
                        n_valid     = 1'b0;
                        n_tok.found = 1'b1;
                        n_tok.f_id  = r_id;
                        n_tok.f_pid = r_pid;
                        n_tok.f_lo  = r_lo;
                        n_tok.f_hi  = r_hi;
                    end
                    if (i_tok.ins && !i_tok.inserted && (!r_valid || hit)) begin
                        n_valid        = 1'b1;
                        n_pid          = i_tok.pid;
                        n_id           = i_tok.newid;
                        n_lo           = i_tok.lo;
                        n_hi           = i_tok.hi;
                        n_tok.inserted = 1'b1;
                    end
                end
                vwwt_pkg::OpCan, vwwt_pkg::OpPur: begin
                    hit = r_valid && !i_tok.found &&
                          ((i_tok.op == vwwt_pkg::OpCan) ? (r_id == i_tok.rid)
                                                         : (r_pid == i_tok.pid));
                    if (hit) begin
                        n_valid     = 1'b0;
                        n_tok.found = 1'b1;
                        n_tok.f_id  = r_id;
                        n_tok.f_pid = r_pid;
                        n_tok.f_lo  = r_lo;
                        n_tok.f_hi  = r_hi;
                    end
                end
                default: begin
                    rmv = r_valid && i_tok.rm_vld &&
                          (i_tok.rm_idx == CELL_IDX[vwwt_pkg::IdxW-1:0]);
                    if (rmv) begin
                        n_valid = 1'b0;
                    end
                    cand = r_valid && !rmv &&
                           (i_tok.rising ? (r_hi < i_tok.nv) : (r_lo > i_tok.nv));
                    if (!i_tok.best_vld) begin
                        better = 1'b1;
                    end else if (i_tok.rising) begin
                        better = (key < bkey) || ((key == bkey) && (r_id < i_tok.best_id));
                    end else begin
                        better = (key > bkey) || ((key == bkey) && (r_id > i_tok.best_id));
                    end
                    if (cand && better) begin
                        n_tok.best_vld = 1'b1;
                        n_tok.best_idx = CELL_IDX[vwwt_pkg::IdxW-1:0];
                        n_tok.best_id  = r_id;
                        n_tok.best_pid = r_pid;
                        n_tok.best_lo  = r_lo;
                        n_tok.best_hi  = r_hi;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_tok.vld <= n_tok.vld;
        end
        r_pid <= n_pid;
        r_id  <= n_id;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        {r_tok.op, r_tok.pid, r_tok.rid, r_tok.lo, r_tok.hi, r_tok.nv, r_tok.rising,
         r_tok.ins, r_tok.inserted, r_tok.newid, r_tok.found, r_tok.f_id, r_tok.f_pid,
         r_tok.f_lo, r_tok.f_hi, r_tok.best_vld, r_tok.best_idx, r_tok.best_id,
         r_tok.best_pid, r_tok.best_lo, r_tok.best_hi, r_tok.rm_vld, r_tok.rm_idx} <=
        {n_tok.op, n_tok.pid, n_tok.rid, n_tok.lo, n_tok.hi, n_tok.nv, n_tok.rising,
         n_tok.ins, n_tok.inserted, n_tok.newid, n_tok.found, n_tok.f_id, n_tok.f_pid,
         n_tok.f_lo, n_tok.f_hi, n_tok.best_vld, n_tok.best_idx, n_tok.best_id,
         n_tok.best_pid, n_tok.best_lo, n_tok.best_hi, n_tok.rm_vld, n_tok.rm_idx};
    end

    assign o_tok = r_tok;

endmodule

FILE: tb/value_window_watch_table_tb.sv
// Testbench for the value window watch table: directed and random requests.
`timescale 1ns / 1ps

module value_window_watch_table_tb;

    localparam int Depth = vwwt_pkg::DefDepth;

    typedef struct packed {
        logic               kind;
        logic [2:0]         status;
        logic [31:0]        rid;
        logic [14:0]        pid;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] cur;
        logic [31:0]        old;
        logic               last;
    } t_note;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_op;
    logic [14:0] i_pid;
    logic [31:0] i_req_id;
    logic signed [31:0] i_low_bound;
    logic signed [31:0] i_high_bound;
    logic signed [31:0] i_new_value;
    logic        o_valid;
    logic        i_ready;
    logic        o_kind;
    logic [2:0]  o_status;
    logic [31:0] o_out_req_id;
    logic [14:0] o_out_pid;
    logic signed [31:0] o_out_low;
    logic signed [31:0] o_out_high;
    logic signed [31:0] o_current_value;
    logic [31:0] o_old_req_id;
    logic        o_last;

    value_window_watch_table uut (.*);

    // predictor state
    logic               w_vld  [Depth];
    logic [14:0]        w_pid  [Depth];
    logic [31:0]        w_id   [Depth];
    logic signed [31:0] w_lo   [Depth];
    logic signed [31:0] w_hi   [Depth];
    logic signed [31:0] level;
    logic [31:0]        id_ctr;

    t_note pending[$];
    int    errors;
    int    send_idle;
    int    recv_idle;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #60000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic t_note mk(logic kind, logic [2:0] st, logic [31:0] rid,
                                 logic [14:0] pid, logic signed [31:0] lo,
                                 logic signed [31:0] hi, logic signed [31:0] cur,
                                 logic [31:0] old, logic last);
        t_note n;
        n.kind = kind; n.status = st; n.rid = rid; n.pid = pid; n.lo = lo;
        n.hi = hi; n.cur = cur; n.old = old; n.last = last;
        return n;
    endfunction

    task automatic predict_watch(logic [1:0] op, logic [14:0] pid, logic [31:0] rid,
                                 logic signed [31:0] lo, logic signed [31:0] hi,
                                 logic signed [31:0] nv);
        logic [2:0]         st;
        logic [31:0]        old;
        logic [31:0]        newid;
        logic [14:0]        opid;
        logic signed [31:0] olo;
        logic signed [31:0] ohi;
        logic signed [31:0] cur;
        logic               rising;
        int                 slot;
        int                 best;
        bit                 done;
        st = vwwt_pkg::StOk; old = 0; newid = 0; opid = 0; olo = 0; ohi = 0; cur = 0;
        slot = -1; done = 0;
        case (op)
            vwwt_pkg::OpReq: begin
                for (int i = 0; i < Depth; i++) begin
                    if (!done && w_vld[i] && w_pid[i] == pid) begin
                        st = vwwt_pkg::StRepl; old = w_id[i]; opid = w_pid[i];
                        olo = w_lo[i]; ohi = w_hi[i]; w_vld[i] = 0; done = 1;
                    end
                end
                if (lo > level || hi < level) begin
                    st = st | vwwt_pkg::StOutWin;
                    cur = level;
                end else begin
                    for (int i = 0; i < Depth; i++)
                        if (slot < 0 && !w_vld[i]) slot = i;
                    if (slot < 0) begin
                        st = vwwt_pkg::StFull;
                    end else begin
                        id_ctr = id_ctr + 1;
                        newid = id_ctr;
                        w_vld[slot] = 1; w_pid[slot] = pid; w_id[slot] = newid;
                        w_lo[slot] = lo; w_hi[slot] = hi;
                    end
                end
                pending.push_back(mk(0, st, newid, opid, olo, ohi, cur, old, 1));
            end
            vwwt_pkg::OpCan, vwwt_pkg::OpPur: begin
                for (int i = 0; i < Depth; i++) begin
                    if (!done && w_vld[i] &&
                        ((op == vwwt_pkg::OpCan) ? (w_id[i] == rid)
                                                 : (w_pid[i] == pid))) begin
                        w_vld[i] = 0; done = 1;
                        pending.push_back(mk(0, vwwt_pkg::StOk, w_id[i], w_pid[i],
                                             w_lo[i], w_hi[i], 0, 0, 1));
                    end
                end
                if (!done)
                    pending.push_back(mk(0, vwwt_pkg::StNotFound, 0, 0, 0, 0, 0, 0, 1));
            end
            default: begin
                rising = nv > level;
                do begin
                    best = -1;
                    for (int i = 0; i < Depth; i++) begin
                        if (!w_vld[i]) continue;
                        if (rising) begin
                            if (w_hi[i] >= nv) continue;
                            if (best < 0 || w_hi[i] < w_hi[best] ||
                                (w_hi[i] == w_hi[best] && w_id[i] < w_id[best]))
                                best = i;
                        end else begin
                            if (w_lo[i] <= nv) continue;
                            if (best < 0 || w_lo[i] > w_lo[best] ||
                                (w_lo[i] == w_lo[best] && w_id[i] > w_id[best]))
                                best = i;
                        end
                    end
                    if (best >= 0) begin
                        w_vld[best] = 0;
                        pending.push_back(mk(1, vwwt_pkg::StOk, w_id[best], w_pid[best],
                                             w_lo[best], w_hi[best], nv, 0, 0));
                    end
                end while (best >= 0);
                level = nv;
                pending.push_back(mk(0, vwwt_pkg::StOk, 0, 0, 0, 0, nv, 0, 1));
            end
        endcase
    endtask

    task automatic send_request(logic [1:0] op, logic [14:0] pid, logic [31:0] rid,
                                logic signed [31:0] lo, logic signed [31:0] hi,
                                logic signed [31:0] nv);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        i_valid <= 1; i_op <= op; i_pid <= pid; i_req_id <= rid;
        i_low_bound <= lo; i_high_bound <= hi; i_new_value <= nv;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_watch(op, pid, rid, lo, hi, nv);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) i_ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        t_note e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending.size() == 0) begin
                $error("unexpected result");
                errors++;
            end else begin
                e = pending.pop_front();
                if (o_kind !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, o_kind); errors++;
                end
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); errors++;
                end
                if (o_out_req_id !== e.rid) begin
                    $error("out_req_id exp %0d got %0d", e.rid, o_out_req_id); errors++;
                end
                if (o_out_pid !== e.pid) begin
                    $error("out_pid exp %0d got %0d", e.pid, o_out_pid); errors++;
                end
                if (o_out_low !== e.lo) begin
                    $error("out_low exp %0d got %0d", e.lo, o_out_low); errors++;
                end
                if (o_out_high !== e.hi) begin
                    $error("out_high exp %0d got %0d", e.hi, o_out_high); errors++;
                end
                if (o_current_value !== e.cur) begin
                    $error("current_value exp %0d got %0d", e.cur, o_current_value);
                    errors++;
                end
                if (o_old_req_id !== e.old) begin
                    $error("old_req_id exp %0d got %0d", e.old, o_old_req_id); errors++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_last); errors++;
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_near(logic signed [31:0] c);
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: return c + $signed($urandom_range(80)) - 40;
        endcase
    endfunction

    task automatic test_directed();
        send_request(vwwt_pkg::OpCan, 0, 32'hffffffff, 0, 0, 0);
        send_request(vwwt_pkg::OpPur, 15'h7fff, 0, 0, 0, 0);
        send_request(vwwt_pkg::OpReq, 1, 0, 32'sh80000000, 32'sh7fffffff, 0);
        send_request(vwwt_pkg::OpReq, 1, 0, -5, 5, 0);
        send_request(vwwt_pkg::OpReq, 1, 0, 10, 20, 0);
        send_request(vwwt_pkg::OpReq, 2, 0, 5, -5, 0);
        for (int i = 0; i < Depth + 1; i++)
            send_request(vwwt_pkg::OpReq, 15'(100 + i), 0, -i, i, 0);
        send_request(vwwt_pkg::OpSet, 0, 0, 0, 0, 32'sh7fffffff);
        send_request(vwwt_pkg::OpReq, 3, 0, 0, 32'sh7fffffff, 0);
        send_request(vwwt_pkg::OpSet, 0, 0, 0, 0, 32'sh80000000);
        send_request(vwwt_pkg::OpCan, 0, 1, 0, 0, 0);
    endtask

    task automatic test_random(int n);
        logic [1:0]  op;
        logic [31:0] rid;
        for (int k = 0; k < n; k++) begin
            op = $urandom_range(9) < 6 ? vwwt_pkg::OpReq : 2'($urandom_range(3));
            rid = ($urandom_range(3) == 0) ? $urandom : id_ctr - $urandom_range(20);
            send_request(op, ($urandom_range(7) == 0) ? 15'($urandom) : 15'($urandom_range(20)),
                         rid,
                         ($urandom_range(9) == 0) ? rand_near(level) : level - $urandom_range(50),
                         ($urandom_range(9) == 0) ? rand_near(level) : level + $urandom_range(50),
                         rand_near(level));
        end
    endtask

    task automatic test_id_wrap();
        // cancels of random ids reach the high id bits
        for (int k = 0; k < 10; k++)
            send_request(vwwt_pkg::OpCan, 0, $urandom, 0, 0, 0);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 0;
        while (pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (3 * (Depth + 2)) @(posedge i_clk);
    endtask

    initial begin
        errors = 0; send_idle = 0; recv_idle = 0;
        i_rst_n <= 0; i_valid <= 0; i_ready <= 0; i_op <= vwwt_pkg::OpReq; i_pid <= 0;
        i_req_id <= 0; i_low_bound <= 0; i_high_bound <= 0; i_new_value <= 0;
        for (int i = 0; i < Depth; i++) begin
            w_vld[i] = 0; w_pid[i] = 0; w_id[i] = 0; w_lo[i] = 0; w_hi[i] = 0;
        end
        level = 0; id_ctr = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        send_idle = 36; recv_idle = 59;
        test_random(144);
        send_idle = 59; recv_idle = 36;
        test_random(144);
        send_idle = 0; recv_idle = 0;
        test_random(144);
        test_id_wrap();
        drain();
        if (errors == 0 && pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
